// ----- rtl/lzwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants, register indexes, FSM states and control structs.
// ----------------------------------------------------------------------------
package lzwc_pkg;

  localparam int WINDOW_SIZE    = 4096;
  localparam int LOOKAHEAD_SIZE = 16;

  localparam int BYTE_W  = 8;
  localparam int MM_W    = 5;
  localparam int CODE_W  = 4;
  localparam int PAY_W   = 12;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 8;

  localparam logic [BYTE_W-1:0] FILL_RESET = 8'd32;
  localparam logic [MM_W-1:0]   MM_RESET   = 5'd2;
  localparam logic [MM_W-1:0]   MM_FLOOR   = 5'd2;

  localparam logic [CFG_IW-1:0] REG_WINDOW_FILL = 1'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_MATCH   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DECIDE,
    ST_COPY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cmp;
    logic decide;
    logic copy;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tok_needed;
    logic search_done;
    logic copy_last;
    logic out_free;
    logic more;
  } sts_t;

endpackage

// ----- rtl/lz77_window_compressor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_window_compressor
// LZ77 token generator over a circular window with a small lookahead.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the controller is idle and the
// lookahead is not full. Each token costs a window scan, serial over the
// window positions: a registered window read (ST_RD) and then a compare
// (ST_CMP) for each byte, with a run per window position that stops at the
// first mismatch; a full-length hit ends the scan early. The token is then
// decided, its bytes are copied into the window one at a time, and it
// is emitted once the output register is free. Window contents not yet
// written in a stream read as the fill byte latched at stream start, so
// no clearing pass is needed.
module lz77_window_compressor #(
  parameter int WINDOW_SIZE    = lzwc_pkg::WINDOW_SIZE,
  parameter int LOOKAHEAD_SIZE = lzwc_pkg::LOOKAHEAD_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lzwc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lzwc_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lzwc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_stream,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lzwc_pkg::CODE_W-1:0] length_code,
  output logic [lzwc_pkg::PAY_W-1:0]  payload,
  output logic                        last_token
);

  lzwc_pkg::cmd_t cmd;
  lzwc_pkg::sts_t sts;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwc_dp #(
    .WINDOW_SIZE    (WINDOW_SIZE),
    .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .length_code   (length_code),
    .payload       (payload),
    .last_token    (last_token),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ----- rtl/lzwc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_ctrl
// Sequencer: accept, window search, token decision, window copy, emit.
// ----------------------------------------------------------------------------
module lzwc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lzwc_pkg::sts_t  sts,
  output lzwc_pkg::cmd_t  cmd
);

  lzwc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lzwc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.tok_needed) state_next = lzwc_pkg::ST_RD;
        end
      end
      lzwc_pkg::ST_RD: begin
        state_next = lzwc_pkg::ST_CMP;
      end
      lzwc_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.search_done ? lzwc_pkg::ST_DECIDE : lzwc_pkg::ST_RD;
      end
      lzwc_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = lzwc_pkg::ST_COPY;
      end
      lzwc_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) state_next = lzwc_pkg::ST_EMIT;
      end
      lzwc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.more ? lzwc_pkg::ST_RD : lzwc_pkg::ST_IDLE;
        end
      end
      default: state_next = lzwc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/lzwc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_dp
// Window memory, lookahead, match search registers and output register.
// ----------------------------------------------------------------------------
module lzwc_dp #(
  parameter int WINDOW_SIZE    = lzwc_pkg::WINDOW_SIZE,
  parameter int LOOKAHEAD_SIZE = lzwc_pkg::LOOKAHEAD_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lzwc_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [lzwc_pkg::CFG_DW-1:0]     cfg_data,
  input  logic [lzwc_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            end_of_stream,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lzwc_pkg::CODE_W-1:0]     length_code,
  output logic [lzwc_pkg::PAY_W-1:0]      payload,
  output logic                            last_token,
  input  lzwc_pkg::cmd_t                  cmd,
  output lzwc_pkg::sts_t                  sts
);

  localparam int AW   = $clog2(WINDOW_SIZE);
  localparam int LAW  = $clog2(LOOKAHEAD_SIZE);
  localparam int CNTW = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int CW   = (CNTW > lzwc_pkg::MM_W) ? CNTW : lzwc_pkg::MM_W;

  logic [lzwc_pkg::BYTE_W-1:0] win_fill, stream_fill;
  logic [lzwc_pkg::MM_W-1:0]   min_match;
  logic                        open;
  logic [AW-1:0]               wp;
  logic                        wrapped;
  logic [lzwc_pkg::BYTE_W-1:0] look [LOOKAHEAD_SIZE];
  logic [LAW-1:0]              head;
  logic [CNTW-1:0]             count;
  logic                        eos_q;
  logic [AW-1:0]               pos;
  logic [CNTW-1:0]             k;
  logic [CNTW-1:0]             best_len;
  logic [AW-1:0]               best_pos;
  logic [CNTW-1:0]             rem;
  logic [lzwc_pkg::CODE_W-1:0] tok_code;
  logic [lzwc_pkg::PAY_W-1:0]  tok_pay;
  logic                        tok_last;

  logic [lzwc_pkg::BYTE_W-1:0] mem [WINDOW_SIZE];
  logic [lzwc_pkg::BYTE_W-1:0] rd_data;
  logic                        rd_ok;

  logic [AW-1:0]               rd_addr;
  logic [LAW-1:0]              lk_idx, head_eff;
  logic [lzwc_pkg::BYTE_W-1:0] lk_byte, win_byte;
  logic                        eq, run_end, better, full, hit;
  logic [CNTW-1:0]             k_inc, run_len, tok_len;
  logic [CW-1:0]               mm;

  assign rd_addr  = pos + AW'(k);
  assign lk_idx   = cmd.cmp ? head + LAW'(k) : head;
  assign lk_byte  = look[lk_idx];
  assign win_byte = rd_ok ? rd_data : stream_fill;
  assign eq       = (win_byte == lk_byte);
  assign k_inc    = k + CNTW'(1);
  assign run_len  = eq ? k_inc : k;
  assign run_end  = !eq || (k_inc == count);
  assign better   = run_len > best_len;
  assign full     = run_len == count;
  assign mm       = (min_match < lzwc_pkg::MM_FLOOR) ? CW'(lzwc_pkg::MM_FLOOR) : CW'(min_match);
  assign hit      = CW'(best_len) >= mm;
  assign tok_len  = hit ? best_len : CNTW'(1);
  assign head_eff = open ? head : '0;

  assign sts.tok_needed  = end_of_stream || (count + CNTW'(1) == CNTW'(LOOKAHEAD_SIZE));
  assign sts.search_done = run_end && ((better && full) || (pos == '1));
  assign sts.copy_last   = rem == CNTW'(1);
  assign sts.out_free    = !out_valid || out_ready;
  assign sts.more        = eos_q && (count != '0);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_ok   <= wrapped || (rd_addr < wp);
    if (cmd.copy) mem[wp] <= look[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) look[head_eff + LAW'(count)] <= data_byte;
    if (cmd.accept && !open) stream_fill <= win_fill;
    if (cmd.accept || cmd.emit) begin
      pos      <= '0;
      k        <= '0;
      best_len <= '0;
      best_pos <= '0;
    end else if (cmd.cmp) begin
      if (!run_end) begin
        k <= k_inc;
      end else begin
        if (better) begin
          best_len <= run_len;
          best_pos <= pos;
        end
        k   <= '0;
        pos <= pos + AW'(1);
      end
    end
    if (cmd.decide) begin
      rem      <= tok_len;
      tok_last <= eos_q && (count == tok_len);
      if (hit) begin
        tok_code <= lzwc_pkg::CODE_W'(CW'(best_len) - mm + CW'(1));
        tok_pay  <= lzwc_pkg::PAY_W'(best_pos);
      end else begin
        tok_code <= '0;
        tok_pay  <= lzwc_pkg::PAY_W'(lk_byte);
      end
    end else if (cmd.copy) begin
      rem <= rem - CNTW'(1);
    end
    if (cmd.emit) begin
      length_code <= tok_code;
      payload     <= tok_pay;
      last_token  <= tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_fill  <= lzwc_pkg::FILL_RESET;
      min_match <= lzwc_pkg::MM_RESET;
      open      <= 1'b0;
      wp        <= '0;
      wrapped   <= 1'b0;
      head      <= '0;
      count     <= '0;
      eos_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lzwc_pkg::REG_WINDOW_FILL: win_fill  <= cfg_data[lzwc_pkg::BYTE_W-1:0];
          lzwc_pkg::REG_MIN_MATCH:   min_match <= cfg_data[lzwc_pkg::MM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        count <= count + CNTW'(1);
        eos_q <= end_of_stream;
        if (!open) begin
          open    <= 1'b1;
          wp      <= '0;
          wrapped <= 1'b0;
          head    <= '0;
        end
      end
      if (cmd.copy) begin
        wp    <= wp + AW'(1);
        head  <= head + LAW'(1);
        count <= count - CNTW'(1);
        if (wp == '1) wrapped <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (eos_q && (count == '0)) open <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sv/lz77_window_compressor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_window_compressor_tb
// Self-checking bench for the LZ77 window compressor.
// ----------------------------------------------------------------------------
// Streams of bytes go in over a valid/ready channel. A scoreboard keeps its
// own window and lookahead, predicts each token and checks tokens in order.
// Phases change the fill byte and minimum match length between streams and
// vary idling on both channels. One long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module lz77_window_compressor_tb;

  localparam longint CYCLE_LIMIT = 300_000_000;

  typedef struct {
    logic [lzwc_pkg::CODE_W-1:0] code;
    logic [lzwc_pkg::PAY_W-1:0]  pos;
    logic                        last;
  } token_t;

  class token_scoreboard;
    logic [7:0]  win[lzwc_pkg::WINDOW_SIZE];
    logic [7:0]  ahead[lzwc_pkg::LOOKAHEAD_SIZE];
    int          wr_ptr, head, count;
    bit          open;
    logic [7:0]  fill;
    logic [4:0]  mm;
    token_t      expected_tokens[$];
    int          errors;

    function void init();
      fill = lzwc_pkg::FILL_RESET;
      mm = lzwc_pkg::MM_RESET;
      count = 0;
      open = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [lzwc_pkg::CFG_IW-1:0] idx, logic [7:0] val);
      if (idx == lzwc_pkg::REG_WINDOW_FILL) fill = val;
      else mm = val[4:0];
    endfunction

    function void make_token(bit last);
      int best_len, best_pos, k, eff_mm, len;
      token_t t;
      best_len = 0;
      best_pos = 0;
      for (int i = 0; i < lzwc_pkg::WINDOW_SIZE; i++) begin
        k = 0;
        while (k < count && ahead[(head + k) % lzwc_pkg::LOOKAHEAD_SIZE] ==
               win[(i + k) % lzwc_pkg::WINDOW_SIZE])
          k++;
        if (k > best_len) begin
          best_len = k;
          best_pos = i;
          if (k == count) break;
        end
      end
      eff_mm = (mm < 2) ? 2 : int'(mm);
      if (best_len >= eff_mm) begin
        len = best_len;
        t.code = lzwc_pkg::CODE_W'(best_len - eff_mm + 1);
        t.pos = lzwc_pkg::PAY_W'(best_pos);
      end else begin
        len = 1;
        t.code = '0;
        t.pos = {4'd0, ahead[head]};
      end
      for (k = 0; k < len; k++)
        win[(wr_ptr + k) % lzwc_pkg::WINDOW_SIZE] =
          ahead[(head + k) % lzwc_pkg::LOOKAHEAD_SIZE];
      wr_ptr = (wr_ptr + len) % lzwc_pkg::WINDOW_SIZE;
      head = (head + len) % lzwc_pkg::LOOKAHEAD_SIZE;
      count -= len;
      t.last = last && (count == 0);
      expected_tokens.push_back(t);
    endfunction

    function void note_input(logic [7:0] b, bit eos);
      if (!open) begin
        foreach (win[i]) win[i] = fill;
        wr_ptr = 0;
        head = 0;
        open = 1;
      end
      ahead[(head + count) % lzwc_pkg::LOOKAHEAD_SIZE] = b;
      count++;
      if (eos) begin
        while (count > 0) make_token(1);
        open = 0;
      end else if (count >= lzwc_pkg::LOOKAHEAD_SIZE) begin
        make_token(0);
      end
    endfunction

    function void check_token(logic [lzwc_pkg::CODE_W-1:0] code,
                              logic [lzwc_pkg::PAY_W-1:0] pos, logic last);
      token_t t;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: code %0d pos %0d last %0b", code, pos, last);
        return;
      end
      t = expected_tokens.pop_front();
      if (code !== t.code || pos !== t.pos || last !== t.last) begin
        errors++;
        if (errors <= 10)
          $display("token mismatch: exp code %0d pos %0d last %0b, got %0d %0d %0b",
                   t.code, t.pos, t.last, code, pos, last);
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic                          clk = 0;
  logic                          rst = 1;
  logic                          cfg_we = 0;
  logic [lzwc_pkg::CFG_IW-1:0]   cfg_index = '0;
  logic [lzwc_pkg::CFG_DW-1:0]   cfg_data = '0;
  logic                          in_valid = 0;
  logic                          in_ready;
  logic [lzwc_pkg::BYTE_W-1:0]   data_byte = '0;
  logic                          end_of_stream = 0;
  logic                          out_valid;
  logic                          out_ready = 0;
  logic [lzwc_pkg::CODE_W-1:0]   length_code;
  logic [lzwc_pkg::PAY_W-1:0]    payload;
  logic                          last_token;

  // values held over from the falling edge, stable until the next rising edge
  logic                          in_ready_s, out_valid_s, out_ready_s, last_s;
  logic [lzwc_pkg::CODE_W-1:0]   code_s;
  logic [lzwc_pkg::PAY_W-1:0]    pay_s;

  token_scoreboard     sb;
  int                  send_idle, recv_idle;
  int                  hold_cycles = 0;
  bit                  hold_req = 0;
  bit                  hold_done = 0;
  longint              cycles = 0;

  lz77_window_compressor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready), .length_code(length_code),
    .payload(payload), .last_token(last_token)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(negedge clk) begin
    in_ready_s <= in_ready;
    out_valid_s <= out_valid;
    out_ready_s <= out_ready;
    code_s <= length_code;
    pay_s <= payload;
    last_s <= last_token;
  end

  always @(posedge clk) begin
    if (!rst && out_valid_s && out_ready_s)
      sb.check_token(code_s, pay_s, last_s);
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cycles <= 60000;
      hold_done <= 1;
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lz77_window_compressor");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit eos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    data_byte <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready_s);
    sb.note_input(b, eos);
  endtask

  // alpha 0: any byte; otherwise bytes from a small alphabet starting at base
  task automatic send_stream(int len, int alpha, logic [7:0] base);
    for (int i = 0; i < len; i++) begin
      if (alpha == 0) send_byte(8'($urandom_range(0, 255)), i == len - 1);
      else send_byte(8'(base + $urandom_range(0, alpha - 1)), i == len - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [lzwc_pkg::CFG_IW-1:0] idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic run_phase(logic [7:0] fill, logic [7:0] mm, int items);
    int sent, len;
    write_reg(lzwc_pkg::REG_WINDOW_FILL, fill);
    write_reg(lzwc_pkg::REG_MIN_MATCH, mm);
    cfg_we <= 0;
    @(posedge clk);
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(0, 3) == 0 ? int'($urandom_range(17, 30))
                                      : int'($urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0: send_stream(len, 0, 8'd0);
        1: send_stream(len, 2, fill);
        default: send_stream(len, 4, 8'($urandom_range(0, 255)));
      endcase
      sent += len;
    end
    settle();
  endtask

  initial begin
    logic [7:0] dir[20];
    sb = new();
    sb.init();
    send_idle = 11;
    recv_idle = 67;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, fill bytes, repeats to force matches, lone byte
    dir = '{8'h00, 8'hff, 8'h20, 8'h20, 8'h20, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41,
            8'h42, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h41, 8'h42, 8'h41, 8'h42, 8'h55};
    foreach (dir[i]) send_byte(dir[i], i == 19);
    send_byte(8'h5a, 1);
    settle();

    run_phase(8'd0, 8'd16, 40);
    run_phase(8'd255, 8'd1, 40);
    send_idle = 67;
    recv_idle = 11;
    run_phase(8'h41, 8'd31, 35);
    run_phase(8'($urandom_range(0, 255)), 8'd0, 40);
    send_idle = 0;
    recv_idle = 0;
    run_phase(8'd32, 8'd3, 25);

    hold_req <= 1;
    send_stream(40, 3, 8'h61);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS lz77_window_compressor");
    end else begin
      $display("FAIL lz77_window_compressor");
    end
    $finish;
  end

endmodule

// ----- lz77_window_compressor.f -----
rtl/lzwc_pkg.sv
rtl/lzwc_ctrl.sv
rtl/lzwc_dp.sv
rtl/lz77_window_compressor.sv
tb/sv/lz77_window_compressor_tb.sv
